// ===== rtl/core/ksmt_pkg.sv =====
// Package for the key set membership table.
// Holds beat types, operation codes and default sizes; no dependencies.
package ksmt_pkg;

  localparam int CapacityDef = 16;
  localparam int KeyWidthDef = 32;
  localparam int InKeyW      = 32;
  localparam int CountOutW   = 5;

  localparam logic [1:0] MODE_QUERY  = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  typedef enum logic [1:0] {
    OP_QUERY,
    OP_INSERT,
    OP_REMOVE
  } op_e;

  typedef struct packed {
    logic [1:0]               mode;
    logic signed [InKeyW-1:0] key;
  } item_t;

  typedef struct packed {
    logic                 found;
    logic [CountOutW-1:0] entry_count;
    logic                 insert_refused;
  } result_t;

  typedef struct packed {
    op_e               op;
    logic [InKeyW-1:0] key;
  } cmd_t;

endpackage

// ===== rtl/core/ksmt_front.sv =====
// Front end of the key set membership table: accepts input beats,
// decodes the mode and holds commands in a two-entry queue. Uses ksmt_pkg.
module ksmt_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  ksmt_pkg::item_t item_i,
  output logic           cmd_valid_o,
  output ksmt_pkg::cmd_t cmd_o,
  input  logic           cmd_take_i
);
  import ksmt_pkg::*;

  localparam logic [1:0] QDepth = 2'd2;

  cmd_t       mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cmd_new;
  logic       wr_en, rd_en;

  always_comb begin
    cmd_new.key = item_i.key;
    case (item_i.mode)
      MODE_INSERT: cmd_new.op = OP_INSERT;
      MODE_REMOVE: cmd_new.op = OP_REMOVE;
      MODE_QUERY:  cmd_new.op = OP_QUERY;
      default:     cmd_new.op = OP_QUERY;
    endcase
  end

  assign full_o      = (cnt_q == QDepth);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rptr_q];
  assign wr_en       = push_i && !full_o;
  assign rd_en       = cmd_take_i && cmd_valid_o;

  always_comb begin
    wptr_d = wptr_q ^ wr_en;
    rptr_d = rptr_q ^ rd_en;
    cnt_d  = cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wptr_q] <= cmd_new;
    end
  end

endmodule

// ===== rtl/core/ksmt_back.sv =====
// Back end of the key set membership table: key slots, match compare,
// free-slot search, count and a two-entry result queue. Uses ksmt_pkg.
module ksmt_back #(
  parameter int CAPACITY  = ksmt_pkg::CapacityDef,
  parameter int KEY_WIDTH = ksmt_pkg::KeyWidthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  ksmt_pkg::cmd_t   cmd_i,
  output logic             cmd_take_o,
  output ksmt_pkg::result_t result_o,
  output logic             empty_o,
  input  logic             pop_i
);
  import ksmt_pkg::*;

  localparam int IdxW = $clog2(CAPACITY);
  localparam int CntW = $clog2(CAPACITY + 1);
  localparam logic [1:0] QDepth = 2'd2;
  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_COMMIT = 1'b1;

  logic                 state_q, state_d;
  logic [KEY_WIDTH-1:0] store_q [CAPACITY];
  logic [CAPACITY-1:0]  valid_q, valid_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [CAPACITY-1:0]  match_q, match_d;
  logic [KEY_WIDTH-1:0] key_q;
  op_e                  op_q;

  logic [KEY_WIDTH+InKeyW-1:0]  key_ext;
  logic [KEY_WIDTH-1:0]         key_in;
  logic [CntW+CountOutW-1:0]    cnt_ext;
  logic                         hit, free_found, do_ins, do_rem, refused, commit;
  logic [IdxW-1:0]              free_idx;
  result_t                      res_new;

  result_t    rmem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] rcnt_q;
  logic       rd_en;

  assign key_ext    = {{KEY_WIDTH{1'b0}}, cmd_i.key};
  assign key_in     = key_ext[KEY_WIDTH-1:0];
  assign cmd_take_o = cmd_valid_i && (state_q == ST_IDLE) && (rcnt_q != QDepth);
  assign commit     = (state_q == ST_COMMIT);

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_d[i] = valid_q[i] && (store_q[i] == key_in);
    end
  end

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  assign hit     = |match_q;
  assign do_ins  = commit && (op_q == OP_INSERT) && !hit && free_found;
  assign refused = commit && (op_q == OP_INSERT) && !hit && !free_found;
  assign do_rem  = commit && (op_q == OP_REMOVE) && hit;

  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    if (do_ins) begin
      valid_d[free_idx] = 1'b1;
      count_d           = count_q + CntW'(1);
    end
    if (do_rem) begin
      valid_d = valid_q & ~match_q;
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (cmd_take_o) state_d = ST_COMMIT;
      ST_COMMIT: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  assign cnt_ext                = {{CountOutW{1'b0}}, count_d};
  assign res_new.found          = hit;
  assign res_new.entry_count    = cnt_ext[CountOutW-1:0];
  assign res_new.insert_refused = refused;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o) begin
      match_q <= match_d;
      key_q   <= key_in;
      op_q    <= cmd_i.op;
    end
    if (do_ins) begin
      store_q[free_idx] <= key_q;
    end
  end

  assign empty_o  = (rcnt_q == 2'd0);
  assign result_o = rmem_q[rptr_q];
  assign rd_en    = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      rcnt_q <= 2'd0;
    end else begin
      wptr_q <= wptr_q ^ commit;
      rptr_q <= rptr_q ^ rd_en;
      rcnt_q <= rcnt_q + {1'b0, commit} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      rmem_q[wptr_q] <= res_new;
    end
  end

endmodule

// ===== rtl/core/key_set_membership_table_unit.sv =====
// Key set membership table: a set of distinct keys in CAPACITY slots.
// Input beats carry a mode (query, insert, remove) and a key; push while
// full is low. Each input beat yields one result beat: found (key held
// before the operation), entry_count (keys held after it, low 5 bits)
// and insert_refused (insert of an absent key into a full table).
// Results wait in a two-entry queue; read them while empty is low and
// pop to advance.
// The back end takes a new command only after committing the last one;
// it compares the key against all slots on taking it and commits the
// update in the next cycle. A beat passes the command queue, compare
// registers and commit state; its result can then be popped.
// A two-entry command queue sits between front and back; pushes are
// taken while the back end works or the receiver stalls, until it fills.
// When the result queue is full the back end holds, then the command
// queue fills and full rises.
// Reset empties both queues, clears all slots and the count.
// Uses ksmt_pkg, ksmt_front and ksmt_back.
module key_set_membership_table_unit #(
  parameter int CAPACITY  = ksmt_pkg::CapacityDef,
  parameter int KEY_WIDTH = ksmt_pkg::KeyWidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  ksmt_pkg::item_t   item_i,
  output logic              empty,
  input  logic              pop,
  output ksmt_pkg::result_t result_o
);
  import ksmt_pkg::*;

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  ksmt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .item_i      (item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  ksmt_back #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .result_o    (result_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

`ifndef SYNTHESIS
  a_refused_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.insert_refused) |-> (result_o.entry_count == CountOutW'(CAPACITY)))
    else $error("insert refused while table not full");

  a_refused_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(result_o.found && result_o.insert_refused))
    else $error("refused insert reports key found");

  a_push_reaches_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> cmd_valid)
    else $error("accepted beat not visible to back end");
`endif

endmodule
